### design/atrp_pkg.sv
// Shared types, widths and constants of the accelerometer tilt pipeline.
// No dependencies; every other design file imports this package.
package atrp_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int TABLE_LEN    = 24;
   localparam int N_STEPS      = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

   localparam int IN_W      = 16;
   localparam int ROLL_W    = 16;
   localparam int PITCH_W   = 15;
   localparam int PRE_SHIFT = 8;
   localparam int V_W       = 27;
   localparam int ANG_W     = 27;
   localparam int SIDE_W    = 27;
   localparam int GAIN_W    = 16;
   localparam int PROD_W    = V_W + GAIN_W + 1;
   localparam int OUT_SHIFT = 9;
   localparam int RND_W     = ANG_W + 1 - OUT_SHIFT;

   localparam logic signed [ANG_W-1:0] DEG180   = ANG_W'(11796480);
   localparam logic [GAIN_W-1:0]       INV_GAIN = GAIN_W'(39797);
   localparam int                      ROLL_LIM  = 23040;
   localparam int                      PITCH_LIM = 11520;

   // One vector in flight: components, accumulated angle, a zero-vector flag
   // and a side word that rides along unchanged through each CORDIC pipeline.
   typedef struct packed {
      logic signed [V_W-1:0]    a;
      logic signed [V_W-1:0]    b;
      logic signed [ANG_W-1:0]  ang;
      logic                     skip;
      logic signed [SIDE_W-1:0] side;
   } cordic_type;

   // atan(2^-i) in degrees, scaled by 65536 and rounded to nearest.
   function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
      logic signed [ANG_W-1:0] r;
      unique case (idx)
         0:       r = ANG_W'(2949120);
         1:       r = ANG_W'(1740967);
         2:       r = ANG_W'(919879);
         3:       r = ANG_W'(466945);
         4:       r = ANG_W'(234379);
         5:       r = ANG_W'(117304);
         6:       r = ANG_W'(58666);
         7:       r = ANG_W'(29335);
         8:       r = ANG_W'(14668);
         9:       r = ANG_W'(7334);
         10:      r = ANG_W'(3667);
         11:      r = ANG_W'(1833);
         12:      r = ANG_W'(917);
         13:      r = ANG_W'(458);
         14:      r = ANG_W'(229);
         15:      r = ANG_W'(115);
         16:      r = ANG_W'(57);
         17:      r = ANG_W'(29);
         18:      r = ANG_W'(14);
         19:      r = ANG_W'(7);
         20:      r = ANG_W'(4);
         21:      r = ANG_W'(2);
         22:      r = ANG_W'(1);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

### design/atrp_pre.sv
// Input register of the tilt pipeline with the half-plane pre-rotation for roll.
// Depends on atrp_pkg.
module atrp_pre import atrp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  logic signed [IN_W-1:0] accel_x,
   input  logic signed [IN_W-1:0] accel_y,
   input  logic signed [IN_W-1:0] accel_z,
   output logic                   out_valid,
   output cordic_type             out_data
);

   logic       valid_ff;
   cordic_type data_ff, data_in;
   logic signed [V_W-1:0] y_sc, z_sc;

   always_comb begin
      y_sc = V_W'(accel_y) <<< PRE_SHIFT;
      z_sc = V_W'(accel_z) <<< PRE_SHIFT;
      data_in.side = SIDE_W'(accel_x);
      data_in.skip = (accel_y == '0) && (accel_z == '0);
      if (accel_z[IN_W-1]) begin
         // Turn the vector by a half turn so the first component is positive.
         data_in.a   = -z_sc;
         data_in.b   = -y_sc;
         data_in.ang = accel_y[IN_W-1] ? -DEG180 : DEG180;
      end else begin
         data_in.a   = z_sc;
         data_in.b   = y_sc;
         data_in.ang = '0;
      end
      if (data_in.skip) begin
         data_in.ang = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### design/atrp_cordic.sv
// Pipelined CORDIC vectoring, one register stage per micro-rotation.
// Depends on atrp_pkg for the vector type, step count and arctangent table.
module atrp_cordic import atrp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic       in_valid,
   input  cordic_type in_data,
   output logic       out_valid,
   output cordic_type out_data
);

   cordic_type st_ff [N_STEPS];
   cordic_type prv   [N_STEPS];
   cordic_type st_in [N_STEPS];
   logic       v_ff  [N_STEPS];

   // One micro-rotation; shifts are arithmetic, so they round toward minus infinity.
   function automatic cordic_type rotate(input cordic_type p, input int sh);
      cordic_type r;
      logic signed [V_W-1:0] da, db;
      r  = p;
      da = p.b >>> sh;
      db = p.a >>> sh;
      if (!p.b[V_W-1]) begin
         r.a   = p.a + da;
         r.b   = p.b - db;
         r.ang = p.ang + atan_entry(sh);
      end else begin
         r.a   = p.a - da;
         r.b   = p.b + db;
         r.ang = p.ang - atan_entry(sh);
      end
      return r;
   endfunction

   for (genvar i = 0; i < N_STEPS; i++) begin : g_step
      if (i == 0) begin : g_first
         assign prv[i] = in_data;
      end else begin : g_next
         assign prv[i] = st_ff[i-1];
      end
      assign st_in[i] = rotate(prv[i], i);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N_STEPS; i++) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= (i == 0) ? in_valid : v_ff[(i == 0) ? 0 : i - 1];
         end
         if (en) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign out_valid = v_ff[N_STEPS-1];
   assign out_data  = st_ff[N_STEPS-1];

endmodule

### design/atrp_gain.sv
// Gain correction of the roll magnitude and set-up of the pitch vector.
// Depends on atrp_pkg; sits between the two atrp_cordic pipelines.
module atrp_gain import atrp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic       in_valid,
   input  cordic_type in_data,
   output logic       out_valid,
   output cordic_type out_data
);

   logic                     v1_ff, v2_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ANG_W-1:0]  roll_ff, roll_in;
   logic signed [SIDE_W-1:0] x_ff;
   cordic_type               data_ff, data_in;
   logic signed [PROD_W-1:0] rnd;
   logic signed [V_W-1:0]    mag, x_sc;

   always_comb begin
      prod_in = PROD_W'(in_data.a) * PROD_W'($signed({1'b0, INV_GAIN}));
      roll_in = in_data.skip ? '0 : in_data.ang;
   end

   always_comb begin
      rnd  = (prod_ff + PROD_W'(32768)) >>> GAIN_W;
      mag  = rnd[PROD_W-1] ? '0 : rnd[V_W-1:0];
      x_sc = {x_ff[V_W-1-PRE_SHIFT:0], {PRE_SHIFT{1'b0}}};
      data_in.a    = mag;
      data_in.b    = -x_sc;
      data_in.ang  = '0;
      data_in.skip = (x_sc == '0) && (mag == '0);
      data_in.side = SIDE_W'(roll_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (en) begin
         prod_ff <= prod_in;
         roll_ff <= roll_in;
         x_ff    <= in_data.side;
         data_ff <= data_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = data_ff;

endmodule

### design/atrp_out.sv
// Rounding, saturation and the output register with its skid stage.
// Depends on atrp_pkg; drives the pipeline enable for all earlier stages.
module atrp_out import atrp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  cordic_type                in_data,
   output logic                      en,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [ROLL_W-1:0]  rsp_roll_angle,
   output logic signed [PITCH_W-1:0] rsp_pitch_angle
);

   logic                      rsp_valid_ff, skid_valid_ff;
   logic signed [ROLL_W-1:0]  roll_ff, skid_roll_ff, roll_in;
   logic signed [PITCH_W-1:0] pitch_ff, skid_pitch_ff, pitch_in;
   logic signed [RND_W-1:0]   roll_r, pitch_r;

   function automatic logic signed [RND_W-1:0] round_ang(input logic signed [ANG_W-1:0] ang);
      logic signed [ANG_W:0] s;
      s = (ANG_W+1)'(ang) + (ANG_W+1)'(256);
      return RND_W'(s >>> OUT_SHIFT);
   endfunction

   always_comb begin
      roll_r  = round_ang(ANG_W'(in_data.side));
      pitch_r = round_ang(in_data.skip ? '0 : in_data.ang);
      if (roll_r > RND_W'(ROLL_LIM)) begin
         roll_in = ROLL_W'(ROLL_LIM);
      end else if (roll_r < -RND_W'(ROLL_LIM)) begin
         roll_in = -ROLL_W'(ROLL_LIM);
      end else begin
         roll_in = roll_r[ROLL_W-1:0];
      end
      if (pitch_r > RND_W'(PITCH_LIM)) begin
         pitch_in = PITCH_W'(PITCH_LIM);
      end else if (pitch_r < -RND_W'(PITCH_LIM)) begin
         pitch_in = -PITCH_W'(PITCH_LIM);
      end else begin
         pitch_in = pitch_r[PITCH_W-1:0];
      end
   end

   // The pipeline moves whenever the skid stage is free to catch its last item.
   assign en = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            roll_ff       <= skid_roll_ff;
            pitch_ff      <= skid_pitch_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= in_valid;
            roll_ff      <= roll_in;
            pitch_ff     <= pitch_in;
         end
      end else if (in_valid && en) begin
         skid_valid_ff <= 1'b1;
         skid_roll_ff  <= roll_in;
         skid_pitch_ff <= pitch_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_roll_angle  = roll_ff;
   assign rsp_pitch_angle = pitch_ff;

endmodule

### design/accel_tilt_roll_pitch.sv
// Top level of the accelerometer tilt block: pre-rotation, roll CORDIC, gain
// correction, pitch CORDIC and output stage. Depends on atrp_pkg and the atrp_* modules.

// The block turns one three-axis accelerometer sample (signed 16-bit counts)
// into roll = atan2(y, z) and pitch = atan2(-x, |(y, z)|), both signed and in
// units of 1/128 degree, rounded to nearest and saturated to +/-180 and +/-90
// degrees. It accepts one item every clock cycle while req_stall is low. Each
// item passes through one input register, one register per micro-rotation in
// each of the two CORDIC pipelines, a product register after the gain multiply
// and a register after rounding, and the output register. A zero vector gives an
// angle of zero. When the result side stalls, one more item is caught in a skid
// register, and only then is req_stall raised and the whole pipeline held.
module accel_tilt_roll_pitch import atrp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [IN_W-1:0]    req_accel_x,
   input  logic signed [IN_W-1:0]    req_accel_y,
   input  logic signed [IN_W-1:0]    req_accel_z,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [ROLL_W-1:0]  rsp_roll_angle,
   output logic signed [PITCH_W-1:0] rsp_pitch_angle
);

   logic       en;
   logic       pre_valid, roll_valid, gain_valid, pitch_valid;
   cordic_type pre_data, roll_data, gain_data, pitch_data;

   // All stages advance together; an input item is taken whenever they move.
   assign req_stall = !en;

   atrp_pre u_pre (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .accel_x   (req_accel_x),
      .accel_y   (req_accel_y),
      .accel_z   (req_accel_z),
      .out_valid (pre_valid),
      .out_data  (pre_data)
   );

   // Roll vectoring; the side word carries x to the pitch set-up.
   atrp_cordic u_roll (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pre_valid),
      .in_data   (pre_data),
      .out_valid (roll_valid),
      .out_data  (roll_data)
   );

   // Magnitude times 1/K becomes the first component of the pitch vector.
   atrp_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (roll_valid),
      .in_data   (roll_data),
      .out_valid (gain_valid),
      .out_data  (gain_data)
   );

   // Pitch vectoring; the side word now carries the finished roll angle.
   atrp_cordic u_pitch (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (gain_valid),
      .in_data   (gain_data),
      .out_valid (pitch_valid),
      .out_data  (pitch_data)
   );

   atrp_out u_out (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (pitch_valid),
      .in_data         (pitch_data),
      .en              (en),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_roll_angle  (rsp_roll_angle),
      .rsp_pitch_angle (rsp_pitch_angle)
   );

endmodule

### design/atrp_checker.sv
// Port-level assertions for the accelerometer tilt block, bound to the top level.
// Depends on atrp_pkg for field widths and range limits.
module atrp_checker import atrp_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic signed [IN_W-1:0]    req_accel_x,
   input logic signed [IN_W-1:0]    req_accel_y,
   input logic signed [IN_W-1:0]    req_accel_z,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic signed [ROLL_W-1:0]  rsp_roll_angle,
   input logic signed [PITCH_W-1:0] rsp_pitch_angle
);

   // A result that is held back stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_roll_angle) && $stable(rsp_pitch_angle))
      else $error("stalled result item changed");

   // Input is held back only while a result waits and the skid stage is full.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && $past(rsp_stall))
      else $error("input stalled without a waiting result item");

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_roll_angle <= ROLL_W'(ROLL_LIM) && rsp_roll_angle >= -ROLL_W'(ROLL_LIM))
      else $error("roll angle out of range");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pitch_angle <= PITCH_W'(PITCH_LIM)
                    && rsp_pitch_angle >= -PITCH_W'(PITCH_LIM))
      else $error("pitch angle out of range");

endmodule

bind accel_tilt_roll_pitch atrp_checker u_atrp_checker (.*);

### tb/tb_accel_tilt_roll_pitch.sv
// Self-checking testbench for accel_tilt_roll_pitch: roll and pitch angles from
// accelerometer samples, checked against an in-bench CORDIC model of the block.
// Depends on atrp_pkg and the design files under design/.
module tb_accel_tilt_roll_pitch import atrp_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   // The pipeline is 2 * CORDIC_STEPS + 4 deep. The bench rotates by the same
   // number of micro-rotations, capped by the length of its arctangent table.
   localparam int PIPE_LATENCY = 2 * CORDIC_STEPS + 4;
   localparam int ROT_STEPS    = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_LIMIT  = 5000;
   localparam int SEG_ITEMS    = 100;
   localparam int N_ROWS       = 22;

   typedef struct packed {
      logic signed [IN_W-1:0] x;
      logic signed [IN_W-1:0] y;
      logic signed [IN_W-1:0] z;
   } sample_type;

   typedef struct packed {
      logic signed [ROLL_W-1:0]  roll;
      logic signed [PITCH_W-1:0] pitch;
   } tilt_type;

   // One directed row: the sample, and a typed-in answer where fixed is set.
   typedef struct packed {
      logic signed [IN_W-1:0]    x;
      logic signed [IN_W-1:0]    y;
      logic signed [IN_W-1:0]    z;
      logic                      fixed;
      logic signed [ROLL_W-1:0]  roll;
      logic signed [PITCH_W-1:0] pitch;
   } tilt_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic signed [IN_W-1:0]    req_accel_x;
   logic signed [IN_W-1:0]    req_accel_y;
   logic signed [IN_W-1:0]    req_accel_z;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic signed [ROLL_W-1:0]  rsp_roll_angle;
   logic signed [PITCH_W-1:0] rsp_pitch_angle;

   // Angles still owed by the block, oldest first.
   tilt_type tilt_due[$];
   int       n_mismatch = 0;
   int       quiet_cycles = 0;

   // Knobs that the stimulus process sets for each stretch of the run.
   bit snd_idle = 1'b0;
   bit rcv_idle = 1'b0;
   bit rcv_hold = 1'b0;

   // atan(2^-i) in degrees, in units of 2^-16 degree, rounded to nearest.
   longint atan_deg16 [0:23] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   // Directed rows: the zero vector, every quadrant boundary, the negative-z
   // half plane with y zero, one and minus one, full-scale corners that hit
   // the saturation limits, and alternating bit patterns. Only the zero vector
   // has an answer that can be written down without working it out.
   tilt_row_type tilt_rows [0:N_ROWS-1] = '{
      '{16'sd0,      16'sd0,      16'sd0,      1'b1, 16'sd0, 15'sd0},
      '{16'sd0,      16'sd0,      16'sd1,      1'b0, 16'sd0, 15'sd0},
      '{16'sd0,      16'sd0,     -16'sd1,      1'b0, 16'sd0, 15'sd0},
      '{16'sd0,      16'sd1,      16'sd0,      1'b0, 16'sd0, 15'sd0},
      '{16'sd0,     -16'sd1,      16'sd0,      1'b0, 16'sd0, 15'sd0},
      '{16'sd0,      16'sd1,     -16'sd1,      1'b0, 16'sd0, 15'sd0},
      '{16'sd0,     -16'sd1,     -16'sd1,      1'b0, 16'sd0, 15'sd0},
      '{16'sd0,      16'sd0,     -16'sd32768,  1'b0, 16'sd0, 15'sd0},
      '{16'sd0,     -16'sd1,     -16'sd32768,  1'b0, 16'sd0, 15'sd0},
      '{16'sd0,      16'sd1,     -16'sd32768,  1'b0, 16'sd0, 15'sd0},
      '{16'sd0,      16'sd32767,  16'sd0,      1'b0, 16'sd0, 15'sd0},
      '{16'sd0,     -16'sd32768,  16'sd0,      1'b0, 16'sd0, 15'sd0},
      '{-16'sd32768, 16'sd0,      16'sd0,      1'b0, 16'sd0, 15'sd0},
      '{16'sd32767,  16'sd0,      16'sd0,      1'b0, 16'sd0, 15'sd0},
      '{16'sd1,      16'sd0,      16'sd0,      1'b0, 16'sd0, 15'sd0},
      '{-16'sd1,     16'sd0,      16'sd0,      1'b0, 16'sd0, 15'sd0},
      '{16'sd32767,  16'sd32767,  16'sd32767,  1'b0, 16'sd0, 15'sd0},
      '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 16'sd0, 15'sd0},
      '{-16'sd32768, 16'sd32767, -16'sd32768,  1'b0, 16'sd0, 15'sd0},
      '{16'sd32767, -16'sd32768,  16'sd32767,  1'b0, 16'sd0, 15'sd0},
      '{16'sd21845, -16'sd21846,  16'sd21845,  1'b0, 16'sd0, 15'sd0},
      '{-16'sd21846, 16'sd21845, -16'sd21846,  1'b0, 16'sd0, 15'sd0}
   };

   accel_tilt_roll_pitch dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_accel_x     (req_accel_x),
      .req_accel_y     (req_accel_y),
      .req_accel_z     (req_accel_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_roll_angle  (rsp_roll_angle),
      .rsp_pitch_angle (rsp_pitch_angle)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // CORDIC vectoring: turns (a, b) onto the positive a axis and adds the angle
   // it turned through to ang. Shifts are arithmetic, so they round toward
   // minus infinity, as the hardware's do.
   task automatic cordic_vector(inout longint a, inout longint b, inout longint ang);
      longint da;
      longint db;
      for (int i = 0; i < ROT_STEPS; i++) begin
         da = b >>> i;
         db = a >>> i;
         if (b >= 0) begin
            a   += da;
            b   -= db;
            ang += atan_deg16[i];
         end else begin
            a   -= da;
            b   += db;
            ang -= atan_deg16[i];
         end
      end
   endtask

   // From 2^-16 degree to 1/128 degree, halves rounded up, then clamped.
   function automatic longint to_out_units(longint ang, longint lim);
      longint r;
      r = (ang + 256) >>> 9;
      if (r > lim)
         r = lim;
      if (r < -lim)
         r = -lim;
      return r;
   endfunction

   // Roll is the angle of (z, y); the magnitude it leaves, with the CORDIC
   // gain taken out, is the adjacent side for pitch against -x. A vector in
   // the negative-z half plane is first turned by half a revolution, with the
   // sign of the starting angle taken from y (y zero counts as positive).
   task automatic predict_tilt(input sample_type s, output tilt_type t);
      longint x;
      longint y;
      longint z;
      longint a;
      longint b;
      longint roll;
      longint pitch;
      longint mag;
      x     = longint'(s.x) * 256;
      y     = longint'(s.y) * 256;
      z     = longint'(s.z) * 256;
      roll  = 0;
      pitch = 0;
      mag   = 0;
      if (y != 0 || z != 0) begin
         if (z < 0) begin
            a    = -z;
            b    = -y;
            roll = (y >= 0) ? longint'(DEG180) : -longint'(DEG180);
         end else begin
            a = z;
            b = y;
         end
         cordic_vector(a, b, roll);
         mag = (a * longint'(INV_GAIN) + 32768) >>> 16;
         if (mag < 0)
            mag = 0;
      end
      if (x != 0 || mag != 0) begin
         a = mag;
         b = -x;
         cordic_vector(a, b, pitch);
      end
      t.roll  = ROLL_W'(to_out_units(roll, ROLL_LIM));
      t.pitch = PITCH_W'(to_out_units(pitch, PITCH_LIM));
   endtask

   function automatic logic signed [IN_W-1:0] corner_value();
      case ($urandom_range(0, 4))
         0:       return -16'sd32768;
         1:       return 16'sd32767;
         2:       return -16'sd1;
         3:       return 16'sd1;
         default: return 16'sd0;
      endcase
   endfunction

   // Every sample is a legal input, so most items are uniform over the full
   // range. The rest lean toward the places where the arithmetic is delicate:
   // tiny vectors, zero axes and full-scale corners.
   function automatic sample_type random_sample();
      sample_type s;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: begin
            s.x = IN_W'($urandom);
            s.y = IN_W'($urandom);
            s.z = IN_W'($urandom);
         end
         6, 7: begin
            s.x = IN_W'(int'($urandom_range(0, 40)) - 20);
            s.y = IN_W'(int'($urandom_range(0, 40)) - 20);
            s.z = IN_W'(int'($urandom_range(0, 40)) - 20);
         end
         8: begin
            s.x = IN_W'($urandom);
            s.y = IN_W'($urandom);
            s.z = IN_W'($urandom);
            if ($urandom_range(0, 1) == 0)
               s.y = '0;
            else
               s.z = '0;
            if ($urandom_range(0, 1) == 0)
               s.x = '0;
         end
         default: begin
            s.x = corner_value();
            s.y = corner_value();
            s.z = corner_value();
         end
      endcase
      return s;
   endfunction

   // Offers one item and waits for the handshake. Called at a rising edge;
   // returns at the edge where the item was taken. The stall read right after
   // the edge is still the value that the block held before it.
   task automatic send_sample(input sample_type s, input bit fixed, input tilt_type want);
      tilt_type t;
      if (snd_idle && $urandom_range(0, 5) == 0) begin
         req_valid   <= 1'b0;
         req_accel_x <= IN_W'($urandom);
         req_accel_y <= IN_W'($urandom);
         req_accel_z <= IN_W'($urandom);
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_accel_x <= s.x;
      req_accel_y <= s.y;
      req_accel_z <= s.z;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (fixed)
         t = want;
      else
         predict_tilt(s, t);
      tilt_due.push_back(t);
   endtask

   // Stops offering items until the block has handed back everything.
   task automatic drain_results();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (tilt_due.size() != 0);
   endtask

   task automatic random_segments(input int n_seg);
      for (int g = 0; g < n_seg; g++) begin
         // Some stretches run with no idling at all on one or both sides.
         snd_idle = ($urandom_range(0, 2) != 0);
         rcv_idle = ($urandom_range(0, 2) != 0);
         for (int k = 0; k < SEG_ITEMS; k++)
            send_sample(random_sample(), 1'b0, '0);
      end
   endtask

   // Receiver: random stall bursts while rcv_idle is set, and on request one
   // long hold-off so that the pipeline and its skid register fill up and the
   // block pushes back on its input.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (rcv_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            rcv_hold = 1'b0;
         end else if (rcv_idle && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Result checker: every item taken from the block is compared with the
   // oldest angle pair still owed.
   always @(posedge clock) begin
      tilt_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (tilt_due.size() == 0) begin
            $error("unexpected result: roll_angle %0d, pitch_angle %0d",
                   rsp_roll_angle, rsp_pitch_angle);
            n_mismatch++;
         end else begin
            want = tilt_due.pop_front();
            if (rsp_roll_angle !== want.roll) begin
               $error("roll_angle: expected %0d, got %0d", want.roll, rsp_roll_angle);
               n_mismatch++;
            end
            if (rsp_pitch_angle !== want.pitch) begin
               $error("pitch_angle: expected %0d, got %0d", want.pitch, rsp_pitch_angle);
               n_mismatch++;
            end
         end
      end
   end

   // Watchdog: a run that stops moving items on both channels for far longer
   // than the longest hold-off and the pipeline latency is hung.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL accel_tilt_roll_pitch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      tilt_row_type row;
      tilt_type     want;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_accel_x = '0;
      req_accel_y = '0;
      req_accel_z = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed rows, back to back.
      for (int r = 0; r < N_ROWS; r++) begin
         row        = tilt_rows[r];
         want.roll  = row.roll;
         want.pitch = row.pitch;
         send_sample(sample_type'{row.x, row.y, row.z}, row.fixed, want);
      end

      // Random items with idling bursts on either side.
      random_segments(8);

      // Let the pipeline run dry, then hold the receiver off for a long
      // stretch while items keep coming, so the input side has to stall.
      drain_results();
      snd_idle = 1'b0;
      rcv_idle = 1'b0;
      rcv_hold = 1'b1;
      for (int k = 0; k < 150; k++)
         send_sample(random_sample(), 1'b0, '0);

      random_segments(8);

      // Last stretch at full rate with no idling anywhere.
      snd_idle = 1'b0;
      rcv_idle = 1'b0;
      for (int k = 0; k < 250; k++)
         send_sample(random_sample(), 1'b0, '0);

      drain_results();
      repeat (PIPE_LATENCY + 4) @(posedge clock);
      if (n_mismatch == 0 && tilt_due.size() == 0)
         $display("PASS accel_tilt_roll_pitch");
      else
         $display("FAIL accel_tilt_roll_pitch");
      $finish;
   end

endmodule
